// ===== rtl/cffs_pkg.sv =====
package cffs_pkg;

    // identifier list geometry
    localparam int LIST_DEPTH = 128;
    localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int SCAN_W     = ($clog2(LIST_DEPTH + 1) > 8) ? $clog2(LIST_DEPTH + 1) : 8;

    // frame queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef logic [LIST_AW-1:0]  t_list_addr;
    typedef logic [SCAN_W-1:0]   t_scan_cnt;
    typedef logic [QUEUE_AW-1:0] t_queue_ptr;
    typedef logic [QUEUE_AW:0]   t_queue_cnt;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // configuration register indexes
    localparam logic CFG_LIST_COUNT = 1'b0;
    localparam logic CFG_LIST_MODE  = 1'b1;

    // list modes
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_ALLOW = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;

    // packet bytes
    localparam logic [7:0] PKT_HEADER   = 8'hAA;
    localparam logic [7:0] PKT_TRAILER  = 8'h55;
    localparam logic [7:0] TYPE_STD     = 8'hC0;
    localparam logic [7:0] TYPE_STD_RTR = 8'hD0;
    localparam logic [7:0] TYPE_EXT     = 8'hE0;
    localparam logic [7:0] TYPE_EXT_RTR = 8'hF0;

    typedef struct packed {
        logic        kind;
        logic [6:0]  entry_index;
        logic [31:0] entry_id;
        logic [28:0] identifier;
        logic        extended;
        logic        remote;
        logic [3:0]  length_code;
        logic [63:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // frame waiting for serialization
    typedef struct packed {
        logic [28:0] identifier;
        logic        extended;
        logic        remote;
        logic [3:0]  length_code;
        logic [63:0] payload;
    } t_frame_desc;

    typedef struct packed {
        logic [7:0] list_count;
        logic [1:0] list_mode;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_SCAN
    } t_front_state;

endpackage

// ===== rtl/cffs_fifo.sv =====
module cffs_fifo
    import cffs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_data,
    input  logic        i_pop,
    output t_frame_desc o_data,
    output t_queue_stat o_stat
);

    t_frame_desc r_mem [QUEUE_DEPTH];
    t_queue_ptr  r_wr_ptr, n_wr_ptr;
    t_queue_ptr  r_rd_ptr, n_rd_ptr;
    t_queue_cnt  r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + t_queue_ptr'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + t_queue_ptr'(1) : r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + t_queue_cnt'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - t_queue_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == t_queue_cnt'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // front only pushes into free space, back only pops a stored frame
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("frame queue underflow");

endmodule

// ===== rtl/cffs_front.sv =====
module cffs_front
    import cffs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    input  t_queue_stat i_q_stat,
    output logic        o_busy,
    output logic        o_push,
    output t_frame_desc o_push_data
);

    t_front_state r_state, n_state;
    t_scan_cnt    r_addr, n_addr;
    logic         r_rd_vld, n_rd_vld;
    t_frame_desc  r_frame, n_frame;
    logic [31:0]  r_rdata;
    logic [31:0]  r_list [LIST_DEPTH];

    logic         accept;
    logic         mem_we;
    t_list_addr   wr_idx;
    t_scan_cnt    limit;
    logic         filter_on;
    logic         hit;
    t_frame_desc  in_desc;

    assign o_busy = (r_state != FRONT_IDLE) || i_q_stat.full;
    assign accept = i_start && !o_busy;
    assign wr_idx = t_list_addr'(i_item.entry_index);

    // entries scanned, clipped to the list size
    assign limit = (t_scan_cnt'(i_cfg.list_count) > t_scan_cnt'(LIST_DEPTH))
                 ? t_scan_cnt'(LIST_DEPTH) : t_scan_cnt'(i_cfg.list_count);
    assign filter_on = (limit != '0)
                    && ((i_cfg.list_mode == MODE_ALLOW) || (i_cfg.list_mode == MODE_BLOCK));
    assign hit = r_rd_vld && (r_rdata == {3'b000, r_frame.identifier});

    always_comb begin
        in_desc.identifier  = i_item.identifier;
        in_desc.extended    = i_item.extended;
        in_desc.remote      = i_item.remote;
        in_desc.length_code = i_item.length_code;
        in_desc.payload     = i_item.payload;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_frame     = r_frame;
        mem_we      = 1'b0;
        o_push      = 1'b0;
        o_push_data = r_frame;
        case (r_state)
            FRONT_IDLE: begin
                if (accept) begin
                    if (i_item.kind == KIND_LOAD) begin
                        mem_we = (32'(i_item.entry_index) < 32'(LIST_DEPTH));
                    end else if (filter_on) begin
                        n_frame = in_desc;
                        n_addr  = '0;
                        n_state = FRONT_SCAN;
                    end else begin
                        o_push      = 1'b1;
                        o_push_data = in_desc;
                    end
                end
            end
            FRONT_SCAN: begin
                if (hit || ((r_addr == limit) && !r_rd_vld)) begin
                    o_push  = (i_cfg.list_mode == MODE_ALLOW) ? hit : !hit;
                    n_state = FRONT_IDLE;
                end else if (r_addr < limit) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + t_scan_cnt'(1);
                end
            end
            default: begin
                n_state = FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FRONT_IDLE;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_addr   <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    // identifier list, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_list[wr_idx] <= i_item.entry_id;
        end
        r_rdata <= r_list[r_addr[LIST_AW-1:0]];
    end

endmodule

// ===== rtl/cffs_back.sv =====
module cffs_back
    import cffs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_desc i_q_data,
    input  t_queue_stat i_q_stat,
    output logic        o_pop,
    output logic        o_strobe,
    output t_out_item   o_result
);

    logic        r_active, n_active;
    t_frame_desc r_desc, n_desc;
    logic [3:0]  r_pos, n_pos;
    logic        r_strobe;
    t_out_item   r_result;

    logic [3:0]  data_pos;
    logic [3:0]  last_pos;
    logic [3:0]  k;
    logic        last_now;
    logic [7:0]  type_byte;
    logic [7:0]  byte_now;

    assign data_pos = r_desc.extended ? 4'd6 : 4'd4;
    assign last_pos = data_pos + 4'd8;
    assign k        = r_pos - data_pos;
    assign last_now = (r_pos == last_pos);

    always_comb begin
        if (r_desc.extended) begin
            type_byte = r_desc.remote ? TYPE_EXT_RTR : TYPE_EXT;
        end else begin
            type_byte = r_desc.remote ? TYPE_STD_RTR : TYPE_STD;
        end
        type_byte = type_byte | {4'b0000, r_desc.length_code};
    end

    always_comb begin
        if (r_pos == 4'd0) begin
            byte_now = PKT_HEADER;
        end else if (r_pos == 4'd1) begin
            byte_now = type_byte;
        end else if (r_pos == 4'd2) begin
            byte_now = r_desc.identifier[7:0];
        end else if (r_pos == 4'd3) begin
            byte_now = r_desc.identifier[15:8];
        end else if (r_desc.extended && (r_pos == 4'd4)) begin
            byte_now = r_desc.identifier[23:16];
        end else if (r_desc.extended && (r_pos == 4'd5)) begin
            byte_now = {3'b000, r_desc.identifier[28:24]};
        end else if (last_now) begin
            byte_now = PKT_TRAILER;
        end else if (k < r_desc.length_code) begin
            byte_now = r_desc.payload[{k[2:0], 3'b000} +: 8];
        end else begin
            byte_now = 8'h00;
        end
    end

    always_comb begin
        o_pop    = !i_q_stat.empty && (!r_active || last_now);
        n_active = r_active;
        n_desc   = r_desc;
        n_pos    = r_pos;
        if (o_pop) begin
            n_active = 1'b1;
            n_desc   = i_q_data;
            n_pos    = 4'd0;
        end else if (r_active) begin
            if (last_now) begin
                n_active = 1'b0;
            end else begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc             <= n_desc;
        r_pos              <= n_pos;
        r_result.out_byte  <= byte_now;
        r_result.last_byte <= r_active && last_now;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // the marked last byte is always the trailer
    a_last_is_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last_byte) |-> (r_result.out_byte == PKT_TRAILER))
        else $error("last byte is not the trailer");

    // a packet that follows directly opens with the header
    a_next_is_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last_byte) ##1 r_strobe |-> (r_result.out_byte == PKT_HEADER))
        else $error("packet does not open with the header");

endmodule

// ===== rtl/can_frame_id_filter_serializer.sv =====
// flow: a load transaction writes the id list; a frame that is not filtered goes straight
//   into the frame queue, a filtered frame first scans the list entries (one read a cycle)
//   and stops early on a match
// throughput: one byte a cycle while a packet is sent, 13 or 15 bytes a packet; busy stays
//   high while the list is scanned and while the two-entry frame queue is full
// reset: synchronous, active low; clears control and config, the id list is not cleared
module can_frame_id_filter_serializer
    import cffs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // item port
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    // configuration write port
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // packet byte stream, no back-pressure
    output logic      o_strobe,
    output t_out_item o_result
);

    // configuration registers
    logic [7:0]  r_list_count;
    logic [1:0]  r_list_mode;
    t_cfg        cfg;

    // front to queue
    logic        q_push;
    t_frame_desc q_push_data;

    // queue to back
    logic        q_pop;
    t_frame_desc q_data;
    t_queue_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_count <= '0;
            r_list_mode  <= MODE_PASS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIST_COUNT: r_list_count <= i_cfg_data;
                CFG_LIST_MODE:  r_list_mode  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.list_count = r_list_count;
    assign cfg.list_mode  = r_list_mode;

    // front: takes transactions, stores list entries, scans the list for frames
    cffs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .i_q_stat    (q_stat),
        .o_busy      (busy),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // short queue of passing frames so the scan and the byte stream overlap
    cffs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    // back: turns one queued frame into its packet, one byte a cycle
    cffs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (q_data),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cffs_pkg::*;

    // generous ceiling, the slowest legal run stays far below it
    localparam int CYCLE_LIMIT   = 600000;
    // a dropped frame still scans up to the whole list after the last byte has come
    localparam int SETTLE_CYCLES = LIST_DEPTH + 24;
    // list mode with no name in the package, behaves like pass-all
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one line of the directed table
    typedef struct {
        t_row_kind    kind;
        t_in_item     item;
        logic         cfg_idx;
        logic [7:0]   cfg_val;
        int           pkt_len;  // bytes typed in below, -1 takes the predicted packet
        logic [119:0] pkt;      // typed packet, first byte in the high bits
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   item_bus;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       o_strobe;
    t_out_item  res_bus;

    // predictor copy of the id list and the two registers
    logic [31:0] id_table [LIST_DEPTH];
    bit          slot_written [LIST_DEPTH];
    logic [7:0]  cur_count;
    logic [1:0]  cur_mode;

    // packet bytes still to come, oldest first
    t_out_item pkt_expect [$];
    t_row      dir_rows [$];
    t_out_item byte_want;

    int cycles;
    int errors;
    int loads_sent;
    int frames_sent;
    int bytes_checked;
    int packets_checked;
    int cfg_writes;

    can_frame_id_filter_serializer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (res_bus)
    );

    always #4 i_clk = ~i_clk;

    // filter decision against the first list_count entries
    function automatic bit id_passes(logic [28:0] ident);
        int n;
        bit hit;
        hit = 1'b0;
        if (cur_count == 8'd0) return 1'b1;
        if (cur_mode != MODE_ALLOW && cur_mode != MODE_BLOCK) return 1'b1;
        // counts above the list depth only scan the whole list
        n = (int'(cur_count) > LIST_DEPTH) ? LIST_DEPTH : int'(cur_count);
        for (int i = 0; i < n; i++)
            if (id_table[i] == {3'b000, ident}) hit = 1'b1;
        return (cur_mode == MODE_ALLOW) ? hit : !hit;
    endfunction

    // update the list on a load, queue the packet bytes of a passing frame
    function automatic void predict_item(t_in_item it);
        logic [7:0] pkt [15];
        int pos;
        int total;
        int ncopy;
        if (it.kind == KIND_LOAD) begin
            if (int'(it.entry_index) < LIST_DEPTH) begin
                id_table[it.entry_index]     = it.entry_id;
                slot_written[it.entry_index] = 1'b1;
            end
            return;
        end
        if (!id_passes(it.identifier)) return;
        for (int k = 0; k < 15; k++) pkt[k] = 8'h00;
        pkt[0] = PKT_HEADER;
        pkt[1] = (it.extended ? (it.remote ? TYPE_EXT_RTR : TYPE_EXT)
                              : (it.remote ? TYPE_STD_RTR : TYPE_STD)) | {4'h0, it.length_code};
        // standard frames still send bits 15..0, no 11-bit mask
        pkt[2] = it.identifier[7:0];
        pkt[3] = it.identifier[15:8];
        pos = 4;
        if (it.extended) begin
            pkt[4] = it.identifier[23:16];
            pkt[5] = {3'b000, it.identifier[28:24]};
            pos = 6;
        end
        // oversized length codes copy at most eight bytes, the rest stays zero
        ncopy = (it.length_code > 4'd8) ? 8 : int'(it.length_code);
        for (int k = 0; k < ncopy; k++) pkt[pos + k] = it.payload[8*k +: 8];
        total = pos + 9;
        pkt[total - 1] = PKT_TRAILER;
        for (int k = 0; k < total; k++)
            pkt_expect.push_back('{out_byte: pkt[k], last_byte: (k == total - 1)});
    endfunction

    function automatic t_in_item mk_frame(logic [28:0] ident, logic ext, logic rtr,
                                          logic [3:0] len, logic [63:0] pay);
        t_in_item it;
        // load fields carry junk, a frame must ignore them
        it.kind        = KIND_FRAME;
        it.entry_index = 7'($urandom);
        it.entry_id    = $urandom;
        it.identifier  = ident;
        it.extended    = ext;
        it.remote      = rtr;
        it.length_code = len;
        it.payload     = pay;
        return it;
    endfunction

    function automatic t_in_item mk_load(logic [6:0] slot, logic [31:0] val);
        t_in_item it;
        // frame fields carry junk, a load must ignore them
        it.kind        = KIND_LOAD;
        it.entry_index = slot;
        it.entry_id    = val;
        it.identifier  = 29'($urandom);
        it.extended    = 1'($urandom);
        it.remote      = 1'($urandom);
        it.length_code = 4'($urandom);
        it.payload     = {$urandom, $urandom};
        return it;
    endfunction

    // random list id, mostly with the top bits clear so that it can match
    function automatic logic [31:0] rand_list_id();
        return {($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000, 29'($urandom)};
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int lim;
        int pick;
        lim  = (int'(cur_count) > LIST_DEPTH) ? LIST_DEPTH : int'(cur_count);
        pick = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            return mk_load(7'($urandom_range(0, LIST_DEPTH - 1)), rand_list_id());
        it = mk_frame(29'($urandom), 1'($urandom), 1'($urandom),
                      ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 8))
                                                  : 4'($urandom_range(9, 15)),
                      {$urandom, $urandom});
        // half the frames reuse a listed id so that hits and misses both happen
        if (lim > 0 && pick < 2)
            it.identifier = id_table[$urandom_range(0, lim - 1)][28:0];
        else if (pick == 2)
            it.identifier = 29'($urandom_range(0, 'h7FF));
        return it;
    endfunction

    function automatic void add_row(t_in_item it, int n, logic [119:0] pkt);
        dir_rows.push_back('{kind: ROW_ITEM, item: it, cfg_idx: 1'b0, cfg_val: 8'h00,
                             pkt_len: n, pkt: pkt});
    endfunction

    function automatic void add_cfg(logic idx, logic [7:0] val);
        dir_rows.push_back('{kind: ROW_CFG, item: '0, cfg_idx: idx, cfg_val: val,
                             pkt_len: 0, pkt: '0});
    endfunction

    // present one transaction, hold it until the block takes it
    task automatic send_item(t_in_item it, int pkt_len, logic [119:0] pkt);
        @(negedge i_clk);
        start    = 1'b1;
        item_bus = it;
        do @(posedge i_clk); while (busy);
        if (it.kind == KIND_LOAD) begin
            loads_sent++;
            predict_item(it);
        end else begin
            frames_sent++;
            if (pkt_len < 0)
                predict_item(it);
            else
                for (int k = 0; k < pkt_len; k++)
                    pkt_expect.push_back('{out_byte: pkt[(pkt_len - 1 - k)*8 +: 8],
                                           last_byte: (k == pkt_len - 1)});
        end
    endtask

    task automatic idle_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 17));
    endtask

    // wait for every expected byte, then let any trailing list scan finish
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pkt_expect.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_LIST_COUNT) cur_count = val;
        else                       cur_mode  = val[1:0];
        cfg_writes++;
    endtask

    // one setting of the registers followed by random traffic
    task automatic run_phase(logic [1:0] mode, logic [7:0] count, int n_items, bit quiet);
        int lim;
        lim = (int'(count) > LIST_DEPTH) ? LIST_DEPTH : int'(count);
        // every slot the scan will read has to hold a written id first
        for (int s = 0; s < lim; s++)
            if (!slot_written[s]) begin
                send_item(mk_load(7'(s), rand_list_id()), -1, '0);
                maybe_idle(quiet);
            end
        drain();
        write_reg(CFG_LIST_MODE, {6'($urandom), mode});
        write_reg(CFG_LIST_COUNT, count);
        repeat (n_items) begin
            send_item(rand_item(), -1, '0);
            maybe_idle(quiet);
        end
    endtask

    // large count over a short freshly written prefix, every frame matches inside it
    // so the scan never runs past the written slots
    task automatic run_hit_phase(logic [1:0] mode, logic [7:0] count, int prefix, int n_items);
        t_in_item it;
        for (int s = 0; s < prefix; s++) begin
            send_item(mk_load(7'(s), {3'b000, 29'($urandom)}), -1, '0);
            maybe_idle(1'b0);
        end
        drain();
        write_reg(CFG_LIST_MODE, {6'($urandom), mode});
        write_reg(CFG_LIST_COUNT, count);
        repeat (n_items) begin
            it = mk_frame(29'($urandom), 1'($urandom), 1'($urandom),
                          4'($urandom_range(0, 8)), {$urandom, $urandom});
            it.identifier = id_table[$urandom_range(0, prefix - 1)][28:0];
            send_item(it, -1, '0);
            maybe_idle(1'b0);
        end
    endtask

    // byte checker, the block cannot be stalled so every strobe is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pkt_expect.size() == 0) begin
                $error("out_byte: expected nothing, actual %h", res_bus.out_byte);
                errors++;
            end else begin
                byte_want = pkt_expect.pop_front();
                if (res_bus.out_byte !== byte_want.out_byte) begin
                    $error("out_byte: expected %h, actual %h",
                           byte_want.out_byte, res_bus.out_byte);
                    errors++;
                end
                if (res_bus.last_byte !== byte_want.last_byte) begin
                    $error("last_byte: expected %b, actual %b",
                           byte_want.last_byte, res_bus.last_byte);
                    errors++;
                end
                bytes_checked++;
                if (byte_want.last_byte) packets_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("can_frame_id_filter_serializer verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        item_bus   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LIST_COUNT;
        i_cfg_data = 8'h00;
        cur_count  = 8'd0;
        cur_mode   = MODE_PASS;
        for (int s = 0; s < LIST_DEPTH; s++) begin
            id_table[s]     = 32'h0;
            slot_written[s] = 1'b0;
        end

        // after reset the list is empty, so every frame passes
        add_row(mk_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'h0), 13,
                {8'hAA, 8'hC0, 16'h0000, 64'h0, 8'h55});
        add_row(mk_frame(29'h1FFFFFFF, 1'b1, 1'b1, 4'd8, 64'hFFFFFFFFFFFFFFFF), 15,
                {8'hAA, 8'hF8, 32'hFFFFFF1F, 64'hFFFFFFFFFFFFFFFF, 8'h55});
        // standard frame sends the low 16 id bits unmasked, length code above eight
        add_row(mk_frame(29'h1FFFFFFF, 1'b0, 1'b0, 4'd15, 64'h0123456789ABCDEF), 13,
                {8'hAA, 8'hCF, 16'hFFFF, 64'hEFCDAB8967452301, 8'h55});
        // remote frame still copies its data bytes
        add_row(mk_frame(29'h7FF, 1'b0, 1'b1, 4'd3, 64'h1122334455667788), 13,
                {8'hAA, 8'hD3, 16'hFF07, 64'h8877660000000000, 8'h55});
        add_row(mk_frame(29'h0ABCDEF1, 1'b1, 1'b0, 4'd0, 64'hFFFFFFFFFFFFFFFF), 15,
                {8'hAA, 8'hE0, 32'hF1DEBC0A, 64'h0, 8'h55});
        // loads give no bytes
        add_row(mk_load(7'd0, 32'h00000123), 0, '0);
        add_row(mk_load(7'd1, 32'h1ABCDEF0), 0, '0);
        add_row(mk_load(7'd2, 32'hE0000456), 0, '0);   // top bits set, never matches
        add_row(mk_load(7'd127, 32'hFFFFFFFF), 0, '0);
        add_row(mk_load(7'd3, 32'h00000000), 0, '0);
        // allow mode with an empty list still passes everything
        add_cfg(CFG_LIST_MODE, {6'd0, MODE_ALLOW});
        add_row(mk_frame(29'h555, 1'b0, 1'b0, 4'd2, 64'hA5A5A5A5A5A5A5A5), -1, '0);
        add_cfg(CFG_LIST_COUNT, 8'd4);
        add_row(mk_frame(29'h123, 1'b0, 1'b0, 4'd8, 64'h8877665544332211), -1, '0);
        add_row(mk_frame(29'h1ABCDEF0, 1'b1, 1'b1, 4'd5, 64'h0F1E2D3C4B5A6978), -1, '0);
        add_row(mk_frame(29'h456, 1'b0, 1'b0, 4'd1, 64'h1), 0, '0);
        add_row(mk_frame(29'h124, 1'b0, 1'b0, 4'd1, 64'h1), 0, '0);
        // block mode drops the listed ids
        add_cfg(CFG_LIST_MODE, {6'd0, MODE_BLOCK});
        add_row(mk_frame(29'h123, 1'b0, 1'b0, 4'd4, 64'hDEADBEEF), 0, '0);
        add_row(mk_frame(29'h124, 1'b0, 1'b1, 4'd4, 64'hDEADBEEF), -1, '0);
        add_row(mk_frame(29'h0, 1'b1, 1'b0, 4'd8, 64'h5A5A5A5A5A5A5A5A), 0, '0);
        // the spare mode passes everything despite the list
        add_cfg(CFG_LIST_MODE, {6'd0, MODE_SPARE});
        add_row(mk_frame(29'h123, 1'b1, 1'b0, 4'd7, 64'hCAFEF00DCAFEF00D), -1, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
            end else begin
                send_item(dir_rows[r].item, dir_rows[r].pkt_len, dir_rows[r].pkt);
                maybe_idle(1'b0);
            end
        end

        // random phases over short lists, then counts above the list depth and a zero count
        run_phase(MODE_ALLOW, 8'd1, 12, 1'b0);
        run_phase(MODE_BLOCK, 8'($urandom_range(2, 8)), 12, 1'b0);
        run_phase(MODE_ALLOW, 8'($urandom_range(1, 16)), 12, $urandom_range(0, 3) == 0);
        run_phase(MODE_SPARE, 8'($urandom_range(1, 12)), 8, 1'b0);
        run_hit_phase(MODE_ALLOW, 8'd255, 6, 6);
        run_hit_phase(MODE_BLOCK, 8'd200, 6, 6);
        run_phase(MODE_BLOCK, 8'd0, 8, 1'b0);
        // closing stretch without any gaps
        run_phase(MODE_PASS, 8'($urandom_range(1, 12)), 14, 1'b1);

        drain();

        $display("covered %0d load and %0d frame transactions over %0d register writes",
                 loads_sent, frames_sent, cfg_writes);
        $display("checked %0d packets, %0d bytes, %0d mismatches",
                 packets_checked, bytes_checked, errors);
        if (errors == 0)
            $display("can_frame_id_filter_serializer verification clean");
        else
            $display("can_frame_id_filter_serializer verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cffs_pkg.sv
rtl/cffs_fifo.sv
rtl/cffs_front.sv
rtl/cffs_back.sv
rtl/can_frame_id_filter_serializer.sv
tb/tb_top.sv
